// ===== design/tmlr_pkg.sv =====
// Shared types and codes for the thick midpoint line rasterizer.
package tmlr_pkg;

    localparam int THICK_BITS = 4;
    localparam int RAD_BITS   = 3;
    localparam int OFF_BITS   = 4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef logic [1:0] dir_t;

    localparam dir_t DIR_NONE = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DOWN = 2'd2;

    // Per-line walk mode: which axis is major and how the minor axis steps.
    typedef struct packed {
        logic major_y;
        dir_t dir;
    } line_mode_t;

endpackage

// ===== design/thick_midpoint_line_rasterizer_core.sv =====
// Thick midpoint line rasterizer: at most one pixel beat per command beat, all octants.
// A start beat (tuser = 0) loads both endpoints and yields the first pixel; each tick
// beat (tuser = 1) yields the next pixel, walking every offset pass of the thick line
// in turn; a tick with no line running is consumed and yields nothing. The block takes
// one beat per cycle sustained unless m_tready stalls the output: a beat is held in the
// input register, where the line setup or the single decision add and compare runs, and
// its pixel is then registered in the result register. tlast marks the final
// pixel of the final pass. Thickness is sampled at each start; zero acts as one.
module thick_midpoint_line_rasterizer_core #(
    parameter int  COORD_BITS = 10,
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * (COORD_BITS + 2) + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tmlr_pkg::THICK_BITS-1:0] cfg_wdata,   // thickness
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_DATA_W-1:0]            s_tdata,     // start_x, start_y, end_x, end_y
    input  logic                            s_tuser,     // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_DATA_W-1:0]           m_tdata,     // pixel_x, pixel_y
    output logic                            m_tlast      // last_pixel
);
    import tmlr_pkg::*;

    localparam int CW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 3;

    // input register
    logic                  in_valid_reg;
    logic                  in_cmd_reg;
    logic [COORD_BITS-1:0] in_sx_reg;
    logic [COORD_BITS-1:0] in_sy_reg;
    logic [COORD_BITS-1:0] in_ex_reg;
    logic [COORD_BITS-1:0] in_ey_reg;

    logic [THICK_BITS-1:0] thickness_reg;

    // line state
    logic                  active_reg;
    logic                  active_next;
    logic [COORD_BITS-1:0] base_x_reg;
    logic [COORD_BITS-1:0] base_x_next;
    logic [COORD_BITS-1:0] base_y_reg;
    logic [COORD_BITS-1:0] base_y_next;
    logic [COORD_BITS-1:0] major_end_reg;
    logic [COORD_BITS-1:0] major_end_next;
    line_mode_t            mode_reg;
    line_mode_t            mode_next;
    logic signed [DW-1:0]  d0_reg;
    logic signed [DW-1:0]  d0_next;
    logic [COORD_BITS:0]   step_s_reg;
    logic [COORD_BITS:0]   step_s_next;
    logic signed [CW-1:0]  step_d_reg;
    logic signed [CW-1:0]  step_d_next;
    logic [RAD_BITS-1:0]   radius_reg;
    logic [RAD_BITS-1:0]   radius_next;
    logic signed [OFF_BITS-1:0] offset_reg;
    logic signed [OFF_BITS-1:0] offset_next;
    logic signed [CW-1:0]  cur_x_reg;
    logic signed [CW-1:0]  cur_x_next;
    logic signed [CW-1:0]  cur_y_reg;
    logic signed [CW-1:0]  cur_y_next;
    logic signed [DW-1:0]  dec_reg;
    logic signed [DW-1:0]  dec_next;

    // result register
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic signed [CW-1:0]  pix_x_reg;
    logic signed [CW-1:0]  pix_y_reg;
    logic                  pix_last_reg;

    // setup outputs
    logic [COORD_BITS-1:0] su_base_x;
    logic [COORD_BITS-1:0] su_base_y;
    logic [COORD_BITS-1:0] su_major_end;
    line_mode_t            su_mode;
    logic signed [DW-1:0]  su_d0;
    logic [COORD_BITS:0]   su_step_s;
    logic signed [CW-1:0]  su_step_d;

    logic                  out_free;
    logic                  advance;
    logic                  emit;
    logic                  last;
    logic signed [CW-1:0]  major_cur;
    logic signed [CW-1:0]  major_nx;
    logic signed [CW-1:0]  minor_step;
    logic [RAD_BITS-1:0]   start_radius;

    // Offset lands on the minor axis of the line.
    function automatic logic signed [CW-1:0] place(
        input logic [COORD_BITS-1:0]     base,
        input logic signed [OFF_BITS-1:0] off,
        input logic                      apply
    );
        logic signed [CW-1:0] off_ext;
        off_ext = {{(CW - OFF_BITS){off[OFF_BITS-1]}}, off};
        return $signed({2'b00, base}) + (apply ? off_ext : '0);
    endfunction

    tmlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .sx        (in_sx_reg),
        .sy        (in_sy_reg),
        .ex        (in_ex_reg),
        .ey        (in_ey_reg),
        .base_x    (su_base_x),
        .base_y    (su_base_y),
        .major_end (su_major_end),
        .mode      (su_mode),
        .d0        (su_d0),
        .step_s    (su_step_s),
        .step_d    (su_step_d)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // thickness 0 and 1 both give radius 0
    assign start_radius = thickness_reg[THICK_BITS-1:1];
    assign major_cur    = mode_reg.major_y ? cur_y_reg : cur_x_reg;

    always_comb
    begin
        active_next    = active_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        major_end_next = major_end_reg;
        mode_next      = mode_reg;
        d0_next        = d0_reg;
        step_s_next    = step_s_reg;
        step_d_next    = step_d_reg;
        radius_next    = radius_reg;
        offset_next    = offset_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        dec_next       = dec_reg;
        minor_step     = '0;
        emit           = 1'b0;

        if (in_cmd_reg == CMD_START)
        begin
            base_x_next    = su_base_x;
            base_y_next    = su_base_y;
            major_end_next = su_major_end;
            mode_next      = su_mode;
            d0_next        = su_d0;
            step_s_next    = su_step_s;
            step_d_next    = su_step_d;
            radius_next    = start_radius;
            offset_next    = -$signed({1'b0, start_radius});
            cur_x_next     = place(su_base_x, offset_next, su_mode.major_y);
            cur_y_next     = place(su_base_y, offset_next, !su_mode.major_y);
            dec_next       = su_d0;
            active_next    = 1'b1;
            emit           = 1'b1;
        end
        else if (active_reg)
        begin
            if (major_cur < $signed({2'b00, major_end_reg}))
            begin
                if (dec_reg[DW-1] || dec_reg == '0)
                begin
                    dec_next = dec_reg + $signed({2'b00, step_s_reg});
                end
                else
                begin
                    dec_next = dec_reg + {step_d_reg[CW-1], step_d_reg};
                    unique case (mode_reg.dir)
                        DIR_UP:   minor_step = CW'(1);
                        DIR_DOWN: minor_step = '1;
                        default:  minor_step = '0;
                    endcase
                end
                if (mode_reg.major_y)
                begin
                    cur_y_next = cur_y_reg + CW'(1);
                    cur_x_next = cur_x_reg + minor_step;
                end
                else
                begin
                    cur_x_next = cur_x_reg + CW'(1);
                    cur_y_next = cur_y_reg + minor_step;
                end
                emit = 1'b1;
            end
            else if (offset_reg < $signed({1'b0, radius_reg}))
            begin
                // next offset pass
                offset_next = offset_reg + OFF_BITS'(1);
                cur_x_next  = place(base_x_reg, offset_next, mode_reg.major_y);
                cur_y_next  = place(base_y_reg, offset_next, !mode_reg.major_y);
                dec_next    = d0_reg;
                emit        = 1'b1;
            end
            else
            begin
                active_next = 1'b0;
            end
        end

        major_nx = mode_next.major_y ? cur_y_next : cur_x_next;
        last     = (major_nx >= $signed({2'b00, major_end_next}))
                   && (offset_next >= $signed({1'b0, radius_next}));
        if (emit && last)
        begin
            active_next = 1'b0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (advance && emit)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            thickness_reg <= THICK_BITS'(1);
            active_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_we)
            begin
                thickness_reg <= cfg_wdata;
            end
            if (advance)
            begin
                active_reg <= active_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg <= s_tuser;
            in_sx_reg  <= s_tdata[COORD_BITS-1:0];
            in_sy_reg  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            in_ex_reg  <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            in_ey_reg  <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        end
        if (advance)
        begin
            base_x_reg    <= base_x_next;
            base_y_reg    <= base_y_next;
            major_end_reg <= major_end_next;
            mode_reg      <= mode_next;
            d0_reg        <= d0_next;
            step_s_reg    <= step_s_next;
            step_d_reg    <= step_d_next;
            radius_reg    <= radius_next;
            offset_reg    <= offset_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            dec_reg       <= dec_next;
        end
        if (advance && emit)
        begin
            pix_x_reg    <= cur_x_next;
            pix_y_reg    <= cur_y_next;
            pix_last_reg <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({pix_y_reg, pix_x_reg});
    assign m_tlast  = pix_last_reg;

    // a waiting final pixel means no line is running
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !active_reg)
        else $error("line still active after final pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (offset_reg <= $signed({1'b0, radius_reg}))
                    && (offset_reg >= -$signed({1'b0, radius_reg})))
        else $error("offset outside radius");

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> major_cur <= $signed({2'b00, major_end_reg}))
        else $error("major axis walked past end point");

    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

// ===== design/tmlr_setup.sv =====
// Line setup: octant, endpoint ordering and midpoint decision terms.
module tmlr_setup #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]        sx,
    input  logic [COORD_BITS-1:0]        sy,
    input  logic [COORD_BITS-1:0]        ex,
    input  logic [COORD_BITS-1:0]        ey,
    output logic [COORD_BITS-1:0]        base_x,
    output logic [COORD_BITS-1:0]        base_y,
    output logic [COORD_BITS-1:0]        major_end,
    output tmlr_pkg::line_mode_t         mode,
    output logic signed [COORD_BITS+2:0] d0,
    output logic [COORD_BITS:0]          step_s,
    output logic signed [COORD_BITS+1:0] step_d
);
    import tmlr_pkg::*;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] dx_abs;
    logic signed [COORD_BITS:0] dy_abs;
    logic [COORD_BITS-1:0]      adx;
    logic [COORD_BITS-1:0]      ady;
    logic [COORD_BITS-1:0]      maj;
    logic [COORD_BITS-1:0]      mnr;
    logic                       major_y;
    logic                       swap;
    logic [COORD_BITS-1:0]      ax;
    logic [COORD_BITS-1:0]      ay;
    logic [COORD_BITS-1:0]      bx;
    logic [COORD_BITS-1:0]      by;
    logic                       minor_pos;
    logic                       minor_neg;

    assign dx     = $signed({1'b0, ex}) - $signed({1'b0, sx});
    assign dy     = $signed({1'b0, ey}) - $signed({1'b0, sy});
    assign dx_abs = dx[COORD_BITS] ? -dx : dx;
    assign dy_abs = dy[COORD_BITS] ? -dy : dy;
    assign adx    = dx_abs[COORD_BITS-1:0];
    assign ady    = dy_abs[COORD_BITS-1:0];

    assign major_y = ady > adx;
    // walk the major axis from low to high
    assign swap    = major_y ? (sy > ey) : (sx > ex);

    assign ax = swap ? ex : sx;
    assign ay = swap ? ey : sy;
    assign bx = swap ? sx : ex;
    assign by = swap ? sy : ey;

    assign maj = major_y ? ady : adx;
    assign mnr = major_y ? adx : ady;

    assign minor_pos = major_y ? (bx > ax) : (by > ay);
    assign minor_neg = major_y ? (bx < ax) : (by < ay);

    always_comb
    begin
        mode.major_y = major_y;
        if (minor_pos)
        begin
            mode.dir = DIR_UP;
        end
        else if (minor_neg)
        begin
            mode.dir = DIR_DOWN;
        end
        else
        begin
            mode.dir = DIR_NONE;
        end
    end

    assign base_x    = ax;
    assign base_y    = ay;
    assign major_end = major_y ? by : bx;

    assign d0     = $signed({2'b00, mnr, 1'b0}) - $signed({3'b000, maj});
    assign step_s = {mnr, 1'b0};
    assign step_d = $signed({1'b0, mnr, 1'b0}) - $signed({1'b0, maj, 1'b0});

endmodule
